### design/apts_pkg.sv
package apts_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_STEREO_ANGLE    = 3'd0,
    REG_CENTRE_RADIUS   = 3'd1,
    REG_LAST_END_RADIUS = 3'd2,
    REG_ROWS_IN_USE     = 3'd3,
    REG_ROW0_WORD       = 3'd4,
    REG_ROW1_WORD       = 3'd5,
    REG_ROW2_WORD       = 3'd6,
    REG_ROW3_WORD       = 3'd7
  } reg_index_t;

  localparam int ROW_REGS   = 4;
  localparam int CFG_WIDTH  = 50;

  // 1/K of the CORDIC gain in Q30, and pi/2 in Q28.
  localparam logic signed [31:0] KINV_Q30    = 32'sd652032874;
  localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;

  // Quotient used when the row pitch is zero.
  localparam logic signed [41:0] QUOT_SAT = 42'sd1099511627776;

  // Input beat.
  typedef struct packed {
    logic               operation;
    logic signed [19:0] pos_eta;
    logic signed [19:0] pos_phi;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic        hit_valid;
    logic [1:0]  row_index;
    logic [11:0] strip_in_row;
    logic [13:0] strip_index;
  } out_t;

  // atan(2^-i) in Q28, rounded.
  function automatic logic [27:0] atan_q28(input int unsigned i);
    logic [27:0] a;
    case (i)
      0:  a = 28'd210828714;
      1:  a = 28'd124459457;
      2:  a = 28'd65760959;
      3:  a = 28'd33381290;
      4:  a = 28'd16755422;
      5:  a = 28'd8385879;
      6:  a = 28'd4193963;
      7:  a = 28'd2097109;
      8:  a = 28'd1048571;
      9:  a = 28'd524287;
      10: a = 28'd262144;
      11: a = 28'd131072;
      12: a = 28'd65536;
      13: a = 28'd32768;
      14: a = 28'd16384;
      15: a = 28'd8192;
      16: a = 28'd4096;
      17: a = 28'd2048;
      18: a = 28'd1024;
      19: a = 28'd512;
      20: a = 28'd256;
      21: a = 28'd128;
      22: a = 28'd64;
      23: a = 28'd32;
      24: a = 28'd16;
      25: a = 28'd8;
      26: a = 28'd4;
      27: a = 28'd2;
      28: a = 28'd1;
      default: a = 28'd0;
    endcase
    return a;
  endfunction

endpackage

### design/annulus_position_to_strip_core.sv
// Channel   Direction  Handshake              Beat
// in        input      in_valid / in_ready    apts_pkg::in_t (operation, pos_eta, pos_phi)
// out       output     out_valid / out_ready  apts_pkg::out_t (hit_valid, row, strips)
// cfg       input      cfg_write              cfg_index, cfg_data (no read-back)
//
// One position is accepted every cycle unless the output stalls; it passes 2*CORDIC_STAGES + 38
// register stages, a depth set by the rotation CORDIC, the vectoring CORDIC and the 31-step
// restoring divider in series.
// Reset (rst, synchronous) clears the stage valid bits and loads the register defaults.
// A stalled output holds every stage in place; in_ready falls only while the output
// register holds a beat that is not taken.
module annulus_position_to_strip_core #(
  parameter int ROWS          = 4,
  parameter int CORDIC_STAGES = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  apts_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output apts_pkg::out_t out_data,
  input  logic           cfg_write,
  input  logic [2:0]     cfg_index,
  input  logic [apts_pkg::CFG_WIDTH-1:0] cfg_data
);

  localparam int N        = CORDIC_STAGES;
  localparam int NROW     = (ROWS < apts_pkg::ROW_REGS) ? ROWS : apts_pkg::ROW_REGS;
  localparam int DIV_BITS = 31;
  localparam int K_MUL    = N + 1;
  localparam int K_SUM    = N + 2;
  localparam int K_PRE    = N + 3;
  localparam int K_VEC0   = N + 4;
  localparam int K_DPREP  = 2 * N + 4;
  localparam int K_DIV0   = 2 * N + 5;
  localparam int K_STRIP  = K_DIV0 + DIV_BITS;
  localparam int K_OUT    = K_STRIP + 1;
  localparam int L        = K_OUT;

  typedef struct packed {
    logic               nearest;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [20:0] dxr;
    logic [39:0]        xx;
    logic [39:0]        yy;
    logic [40:0]        rsq;
    logic               bad;
    logic [1:0]         row;
    logic signed [31:0] rc;
    logic signed [31:0] rs;
    logic signed [31:0] rz;
    logic signed [52:0] m1;
    logic signed [52:0] m2;
    logic signed [52:0] m3;
    logic signed [52:0] m4;
    logic signed [55:0] vx;
    logic signed [55:0] vy;
    logic signed [32:0] vz;
    logic               zero;
    logic               neg;
    logic [30:0]        num;
    logic [30:0]        quo;
    logic [19:0]        rem;
    logic [19:0]        pitch;
    logic [11:0]        cnt;
    logic signed [41:0] strip;
    logic               hv;
    logic [11:0]        sir;
    logic [13:0]        sidx;
  } pipe_t;

  // Configuration registers.
  logic signed [24:0] stereo_angle;
  logic [17:0]        centre_radius;
  logic [17:0]        last_end_radius;
  logic [2:0]         rows_in_use;
  logic [49:0]        row_word [apts_pkg::ROW_REGS];

  // Registered values derived from the configuration.
  logic [2:0]  nrows;
  logic [35:0] endsq;
  logic [35:0] startsq [apts_pkg::ROW_REGS];
  logic [13:0] prefix [apts_pkg::ROW_REGS];

  pipe_t      st [L+1];
  logic [L:0] v;
  logic       en;
  pipe_t      nx0;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_angle    <= '0;
      centre_radius   <= '0;
      last_end_radius <= '0;
      rows_in_use     <= 3'd1;
      for (int i = 0; i < apts_pkg::ROW_REGS; i++) begin
        row_word[i] <= '0;
      end
    end else if (cfg_write) begin
      case (apts_pkg::reg_index_t'(cfg_index))
        apts_pkg::REG_STEREO_ANGLE:    stereo_angle    <= cfg_data[24:0];
        apts_pkg::REG_CENTRE_RADIUS:   centre_radius   <= cfg_data[17:0];
        apts_pkg::REG_LAST_END_RADIUS: last_end_radius <= cfg_data[17:0];
        apts_pkg::REG_ROWS_IN_USE:     rows_in_use     <= cfg_data[2:0];
        apts_pkg::REG_ROW0_WORD:       row_word[0]     <= cfg_data[49:0];
        apts_pkg::REG_ROW1_WORD:       row_word[1]     <= cfg_data[49:0];
        apts_pkg::REG_ROW2_WORD:       row_word[2]     <= cfg_data[49:0];
        apts_pkg::REG_ROW3_WORD:       row_word[3]     <= cfg_data[49:0];
        default: ;
      endcase
    end
  end

  // Squared radii, prefix strip counts and the clamped row count.
  always_ff @(posedge clk) begin
    if (rows_in_use == 3'd0) begin
      nrows <= 3'd1;
    end else if (rows_in_use > 3'(NROW)) begin
      nrows <= 3'(NROW);
    end else begin
      nrows <= rows_in_use;
    end
    endsq <= 36'(last_end_radius) * 36'(last_end_radius);
    for (int i = 0; i < apts_pkg::ROW_REGS; i++) begin
      startsq[i] <= 36'(row_word[i][17:0]) * 36'(row_word[i][17:0]);
    end
    prefix[0] <= '0;
    prefix[1] <= 14'(row_word[0][49:38]);
    prefix[2] <= 14'(row_word[0][49:38]) + 14'(row_word[1][49:38]);
    prefix[3] <= 14'(row_word[0][49:38]) + 14'(row_word[1][49:38])
               + 14'(row_word[2][49:38]);
  end

  // The whole pipeline advances unless the output beat is held.
  assign en        = !v[L] || out_ready;
  assign in_ready  = en;
  assign out_valid = v[L];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[L-1:0], in_valid};
    end
  end

  // Input register; the rotation CORDIC starts from 1/K at minus the stereo angle.
  always_comb begin
    nx0         = '0;
    nx0.nearest = in_data.operation;
    nx0.x       = in_data.pos_eta;
    nx0.y       = in_data.pos_phi;
    nx0.rc      = apts_pkg::KINV_Q30;
    nx0.rs      = '0;
    nx0.rz      = -32'(stereo_angle);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= nx0;
    end
  end

  for (genvar k = 1; k <= L; k++) begin : g_stage
    pipe_t nx;

    if (k <= N) begin : g_rot
      // Rotation CORDIC step; the first stages also square the radius and pick the row.
      logic signed [31:0] cx;
      logic signed [31:0] sx;
      logic               ccw;
      logic signed [3:0]  r;
      logic               found;

      assign ccw = !st[k-1].rz[31];

      apts_cordic_step #(.WIDTH(32), .SHIFT(k - 1)) u_step (
        .x      (st[k-1].rc),
        .y      (st[k-1].rs),
        .ccw    (ccw),
        .x_next (cx),
        .y_next (sx)
      );

      always_comb begin
        nx    = st[k-1];
        r     = '0;
        found = 1'b0;
        nx.rc = cx;
        nx.rs = sx;
        if (ccw) begin
          nx.rz = st[k-1].rz - 32'(apts_pkg::atan_q28(k - 1));
        end else begin
          nx.rz = st[k-1].rz + 32'(apts_pkg::atan_q28(k - 1));
        end
        if (k == 1) begin
          nx.xx  = 40'(40'(st[0].x) * 40'(st[0].x));
          nx.yy  = 40'(40'(st[0].y) * 40'(st[0].y));
          nx.dxr = 21'(st[0].x) - $signed({3'b000, centre_radius});
        end
        if (k == 2) begin
          nx.rsq = 41'(st[1].xx) + 41'(st[1].yy);
        end
        if (k == 3) begin
          nx.bad = (st[2].rsq < 41'(startsq[0])) || (st[2].rsq >= 41'(endsq));
          if (st[2].nearest) begin
            if (st[2].rsq < 41'(startsq[0])) begin
              nx.rsq = 41'(startsq[0]);
            end
            if (nx.rsq >= 41'(endsq)) begin
              nx.rsq = 41'(endsq);
            end
          end
        end
        if (k == 4) begin
          r = $signed({1'b0, nrows}) - 4'sd1;
          for (int i = 0; i < apts_pkg::ROW_REGS; i++) begin
            if (!found && 3'(i) < nrows && 41'(startsq[i]) > st[3].rsq) begin
              r     = 4'(i) - 4'sd1;
              found = 1'b1;
            end
          end
          if (r < 0) begin
            r = '0;
          end
          nx.row = r[1:0];
        end
      end
    end else if (k == K_MUL) begin : g_mul
      // Rotate about the centre radius: products first.
      always_comb begin
        nx    = st[k-1];
        nx.m1 = 53'(st[k-1].rc) * 53'(st[k-1].dxr);
        nx.m2 = 53'(st[k-1].rs) * 53'(st[k-1].y);
        nx.m3 = 53'(st[k-1].rs) * 53'(st[k-1].dxr);
        nx.m4 = 53'(st[k-1].rc) * 53'(st[k-1].y);
      end
    end else if (k == K_SUM) begin : g_sum
      logic signed [53:0] xs;
      logic signed [53:0] ys;

      assign xs = 54'(st[k-1].m1) - 54'(st[k-1].m2)
                + $signed({6'b000000, centre_radius, 30'b0});
      assign ys = 54'(st[k-1].m3) + 54'(st[k-1].m4);

      always_comb begin
        nx    = st[k-1];
        nx.vx = 56'(xs);
        nx.vy = 56'(ys);
      end
    end else if (k == K_PRE) begin : g_pre
      // Turn the left half plane by a quarter turn before vectoring.
      always_comb begin
        nx      = st[k-1];
        nx.zero = (st[k-1].vx == '0) && (st[k-1].vy == '0);
        nx.vz   = '0;
        if (st[k-1].vx < 0) begin
          if (st[k-1].vy >= 0) begin
            nx.vx = st[k-1].vy;
            nx.vy = -st[k-1].vx;
            nx.vz = apts_pkg::HALF_PI_Q28;
          end else begin
            nx.vx = -st[k-1].vy;
            nx.vy = st[k-1].vx;
            nx.vz = -apts_pkg::HALF_PI_Q28;
          end
        end
      end
    end else if (k < K_DPREP) begin : g_vec
      // Vectoring CORDIC step toward the x axis.
      logic signed [55:0] cx;
      logic signed [55:0] sx;
      logic               ccw;

      assign ccw = st[k-1].vy[55];

      apts_cordic_step #(.WIDTH(56), .SHIFT(k - K_VEC0)) u_step (
        .x      (st[k-1].vx),
        .y      (st[k-1].vy),
        .ccw    (ccw),
        .x_next (cx),
        .y_next (sx)
      );

      always_comb begin
        nx    = st[k-1];
        nx.vx = cx;
        nx.vy = sx;
        if (ccw) begin
          nx.vz = st[k-1].vz - 33'(apts_pkg::atan_q28(k - K_VEC0));
        end else begin
          nx.vz = st[k-1].vz + 33'(apts_pkg::atan_q28(k - K_VEC0));
        end
      end
    end else if (k == K_DPREP) begin : g_dprep
      // Split the angle into sign and magnitude and fetch the row geometry.
      logic signed [32:0] phi;

      assign phi = st[k-1].zero ? '0 : st[k-1].vz;

      always_comb begin
        nx       = st[k-1];
        nx.neg   = phi[32];
        nx.num   = phi[32] ? 31'(-phi) : 31'(phi);
        nx.quo   = '0;
        nx.rem   = '0;
        nx.pitch = row_word[st[k-1].row][37:18];
        nx.cnt   = row_word[st[k-1].row][49:38];
      end
    end else if (k < K_STRIP) begin : g_div
      // Restoring division, one quotient bit per stage.
      logic [20:0] trial;
      logic        ge;

      assign trial = {st[k-1].rem, st[k-1].num[30]};
      assign ge    = trial >= {1'b0, st[k-1].pitch};

      always_comb begin
        nx     = st[k-1];
        nx.rem = ge ? 20'(trial - {1'b0, st[k-1].pitch}) : trial[19:0];
        nx.quo = {st[k-1].quo[29:0], ge};
        nx.num = {st[k-1].num[29:0], 1'b0};
      end
    end else if (k == K_STRIP) begin : g_strip
      // Floor quotient, then offset by half the strip count.
      logic [41:0]        qm;
      logic signed [41:0] q;
      logic signed [41:0] s;

      always_comb begin
        qm = {11'b0, st[k-1].quo};
        if (st[k-1].pitch == '0) begin
          q = st[k-1].neg ? -apts_pkg::QUOT_SAT : apts_pkg::QUOT_SAT;
        end else if (st[k-1].neg) begin
          q = $signed(-qm - 42'(st[k-1].rem != '0));
        end else begin
          q = $signed(qm);
        end
        s = q + $signed({31'b0, st[k-1].cnt[11:1]});
        if (st[k-1].cnt[0] && s < 0) begin
          s = s + 42'sd1;
        end
        nx       = st[k-1];
        nx.strip = s;
      end
    end else begin : g_out
      // Range check or clamp, then the flat index.
      logic signed [41:0] s;
      logic signed [41:0] cntx;
      logic               ok;

      always_comb begin
        nx   = st[k-1];
        cntx = $signed({30'b0, st[k-1].cnt});
        s    = st[k-1].strip;
        ok   = 1'b1;
        if (st[k-1].nearest) begin
          if (s < 0) begin
            s = '0;
          end
          if (s >= cntx) begin
            s = cntx - 42'sd1;
          end
          if (s < 0) begin
            s  = '0;
            ok = 1'b0;
          end
        end else if (st[k-1].bad || s < 0 || s >= cntx) begin
          ok = 1'b0;
        end
        if (st[k-1].nearest || ok) begin
          nx.hv   = ok;
          nx.sir  = s[11:0];
          nx.sidx = prefix[st[k-1].row] + s[13:0];
        end else begin
          nx.hv   = 1'b0;
          nx.row  = '0;
          nx.sir  = '0;
          nx.sidx = '0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= nx;
      end
    end
  end

  assign out_data.hit_valid    = st[L].hv;
  assign out_data.row_index    = st[L].row;
  assign out_data.strip_in_row = st[L].sir;
  assign out_data.strip_index  = st[L].sidx;

endmodule

### design/apts_cordic_step.sv
module apts_cordic_step #(
  parameter int WIDTH = 32,
  parameter int SHIFT = 0
) (
  input  logic signed [WIDTH-1:0] x,
  input  logic signed [WIDTH-1:0] y,
  input  logic                    ccw,
  output logic signed [WIDTH-1:0] x_next,
  output logic signed [WIDTH-1:0] y_next
);

  logic signed [WIDTH-1:0] xs;
  logic signed [WIDTH-1:0] ys;

  // Arithmetic shifts round toward minus infinity.
  assign xs = x >>> SHIFT;
  assign ys = y >>> SHIFT;

  // One micro-rotation, counterclockwise or clockwise.
  assign x_next = ccw ? x - ys : x + ys;
  assign y_next = ccw ? y + xs : y - xs;

endmodule
